// ===== rtl/core/palette_scaler_scanout_macros.svh =====
// assertion macros for the palette scaler scan-out block
// no dependencies; used by palette_scaler_scanout.sv
`ifndef PALETTE_SCALER_SCANOUT_MACROS_SVH
`define PALETTE_SCALER_SCANOUT_MACROS_SVH

`ifndef SYNTH
// condition that must hold at every clock edge out of reset
`define PSS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// condition that must hold in the cycle after the trigger
`define PSS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define PSS_ASSERT(lbl, cond, msg)
`define PSS_ASSERT_NEXT(lbl, trig, cond, msg)
`endif

`endif

// ===== rtl/core/pss_pkg.sv =====
// shared types, codes and colour conversion for the palette scaler scan-out
// no dependencies
package pss_pkg;

  // field widths fixed by the interface
  localparam int COL_W     = 11;
  localparam int DIM_W     = 12;
  localparam int XSTEP_W   = 25;
  localparam int YSTEP_W   = 24;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 3;
  localparam int RGB_W     = 24;
  localparam int DIM_CAP   = 2048;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_WR_PALETTE = 2'd0,
    OP_WR_PIXEL   = 2'd1,
    OP_EMIT       = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP      = 3'd4;

  // raw rgb to rgb565 (fmt high) or 24-bit rgb
  function automatic logic [RGB_W-1:0] convert_color(input logic [RGB_W-1:0] rgb,
                                                     input logic fmt);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    if (fmt) begin
      convert_color = {8'd0, r[7:3], g[7:2], b[7:3]};
    end else begin
      convert_color = rgb;
    end
  endfunction

endpackage

// ===== rtl/core/pss_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/palette_scaler_scanout.sv =====
// top level of the palette scaler scan-out: nearest-neighbour scaler with palette lookup
// depends on pss_pkg, pss_ram and palette_scaler_scanout_macros.svh
//
//   channel   handshake                  payload
//   in        in_valid / in_ready        operation, palette_index, red, green, blue,
//                                        source_address, source_pixel
//   out       out_valid / out_ready      pixel_color, dest_x, dest_y, end_of_line,
//                                        end_of_frame
//   cfg       cfg_write_en (no wait)     cfg_index, cfg_data
//
// one word accepted per cycle while the skid stage is empty; a pixel request passes
// through the multiply at the accepting edge, then saturate, address, frame ram,
// palette ram and the output register.
// writes to frame and palette memories happen in order in the same stage as their reads.
// reset clears scan counters, pipe valids and config; memories are not cleared.
// a full skid stage behind the output register stops the whole pipe; one waiting word
// does not hold off the input.
`include "palette_scaler_scanout_macros.svh"

module palette_scaler_scanout #(
  parameter int SRC_WIDTH    = 320,
  parameter int SRC_HEIGHT   = 200,
  parameter int PALETTE_SIZE = 256,
  parameter int MAX_DEST_DIM = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [7:0]                     palette_index,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic [15:0]                    source_address,
  input  logic [7:0]                     source_pixel,
  // output words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pss_pkg::RGB_W-1:0]      pixel_color,
  output logic [pss_pkg::COL_W-1:0]      dest_x,
  output logic [pss_pkg::COL_W-1:0]      dest_y,
  output logic                           end_of_line,
  output logic                           end_of_frame,
  // configuration
  input  logic                           cfg_write_en,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pss_pkg::CFG_W-1:0]      cfg_data
);
  import pss_pkg::*;

  localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int PAL_AW      = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int SX_W        = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int SY_W        = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int DIM_LIM     = (MAX_DEST_DIM < DIM_CAP) ? MAX_DEST_DIM : DIM_CAP;
  localparam int PX_W        = COL_W + XSTEP_W;
  localparam int PY_W        = COL_W + YSTEP_W;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       pal_idx;
    logic [RGB_W-1:0] rgb;
    logic [15:0]      src_addr;
    logic [7:0]       src_pix;
    logic [COL_W-1:0] dx;
    logic [COL_W-1:0] dy;
    logic             eol;
    logic             eof;
  } item_t;

  typedef struct packed {
    logic [RGB_W-1:0] color;
    logic [COL_W-1:0] dx;
    logic [COL_W-1:0] dy;
    logic             eol;
    logic             eof;
  } result_t;

  // configuration registers
  logic               out_format;
  logic [DIM_W-1:0]   dest_width;
  logic [DIM_W-1:0]   dest_height;
  logic [XSTEP_W-1:0] x_step;
  logic [YSTEP_W-1:0] y_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_format  <= 1'b0;
      dest_width  <= DIM_W'(640);
      dest_height <= DIM_W'(400);
      x_step      <= XSTEP_W'(32768);
      y_step      <= YSTEP_W'(32768);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_OUT_FORMAT:  out_format  <= cfg_data[0];
        CFG_DEST_WIDTH:  dest_width  <= cfg_data[DIM_W-1:0];
        CFG_DEST_HEIGHT: dest_height <= cfg_data[DIM_W-1:0];
        CFG_X_STEP:      x_step      <= cfg_data[XSTEP_W-1:0];
        CFG_Y_STEP:      y_step      <= cfg_data[YSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe control: everything moves unless the skid stage is occupied
  logic    adv;
  logic    acc;
  logic    skid_valid;
  result_t head;
  result_t skid;

  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  // effective destination size and line/frame flags
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [COL_W-1:0] scan_column;
  logic [COL_W-1:0] scan_row;
  logic             eol0;
  logic             eof0;
  logic             emit0;

  always_comb begin
    if (dest_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (dest_width > DIM_W'(DIM_LIM)) begin
      w_eff = DIM_W'(DIM_LIM);
    end else begin
      w_eff = dest_width;
    end
    if (dest_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (dest_height > DIM_W'(DIM_LIM)) begin
      h_eff = DIM_W'(DIM_LIM);
    end else begin
      h_eff = dest_height;
    end
  end

  assign eol0  = DIM_W'(scan_column) >= (w_eff - DIM_W'(1));
  assign eof0  = eol0 && (DIM_W'(scan_row) >= (h_eff - DIM_W'(1)));
  assign emit0 = acc && (operation == OP_EMIT);

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= '0;
      scan_row    <= '0;
    end else if (emit0) begin
      if (eol0) begin
        scan_column <= '0;
        scan_row    <= eof0 ? '0 : scan_row + COL_W'(1);
      end else begin
        scan_column <= scan_column + COL_W'(1);
      end
    end
  end

  // pipe valids
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 1: scale the counters
  item_t            it1, it2, it3, it4, it5;
  logic [PX_W-1:0]  px1;
  logic [PY_W-1:0]  py1;

  always_ff @(posedge clk) begin
    if (adv) begin
      it1.op       <= operation;
      it1.pal_idx  <= palette_index;
      it1.rgb      <= {red, green, blue};
      it1.src_addr <= source_address;
      it1.src_pix  <= source_pixel;
      it1.dx       <= scan_column;
      it1.dy       <= scan_row;
      it1.eol      <= eol0;
      it1.eof      <= eof0;
      px1          <= PX_W'(scan_column) * PX_W'(x_step);
      py1          <= PY_W'(scan_row) * PY_W'(y_step);
    end
  end

  // stage 2: drop the fraction and saturate at the last column or row
  logic [PX_W-FRAC_BITS-1:0] px_int;
  logic [PY_W-FRAC_BITS-1:0] py_int;
  logic [SX_W-1:0]           sx2;
  logic [SY_W-1:0]           sy2;

  assign px_int = px1[PX_W-1:FRAC_BITS];
  assign py_int = py1[PY_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      it2 <= it1;
      sx2 <= (px_int > (PX_W-FRAC_BITS)'(SRC_WIDTH - 1)) ? SX_W'(SRC_WIDTH - 1)
                                                         : SX_W'(px_int);
      sy2 <= (py_int > (PY_W-FRAC_BITS)'(SRC_HEIGHT - 1)) ? SY_W'(SRC_HEIGHT - 1)
                                                          : SY_W'(py_int);
    end
  end

  // stage 3: linear frame address
  logic [FRAME_AW-1:0] faddr3;

  always_ff @(posedge clk) begin
    if (adv) begin
      it3    <= it2;
      faddr3 <= FRAME_AW'(sy2) * FRAME_AW'(SRC_WIDTH) + FRAME_AW'(sx2);
    end
  end

  // frame memory: pixel writes and reads in stream order
  logic       frame_wr;
  logic [7:0] frame_rd_data;

  assign frame_wr = adv && v3 && (it3.op == OP_WR_PIXEL) &&
                    (32'(it3.src_addr) < 32'(FRAME_DEPTH));

  pss_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (frame_wr),
    .wr_addr (FRAME_AW'(it3.src_addr)),
    .wr_data (it3.src_pix),
    .rd_en   (adv),
    .rd_addr (faddr3),
    .rd_data (frame_rd_data)
  );

  // stage 4: frame data indexes the palette
  always_ff @(posedge clk) begin
    if (adv) begin
      it4 <= it3;
    end
  end

  logic             pal_wr;
  logic [RGB_W-1:0] pal_rd_data;
  logic             pix_ok5;

  assign pal_wr = adv && v4 && (it4.op == OP_WR_PALETTE) &&
                  (9'(it4.pal_idx) < 9'(PALETTE_SIZE));

  pss_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_SIZE)
  ) u_palette_ram (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (PAL_AW'(it4.pal_idx)),
    .wr_data (it4.rgb),
    .rd_en   (adv),
    .rd_addr (PAL_AW'(frame_rd_data)),
    .rd_data (pal_rd_data)
  );

  // stage 5: palette colour ready
  always_ff @(posedge clk) begin
    if (adv) begin
      it5     <= it4;
      pix_ok5 <= 9'(frame_rd_data) < 9'(PALETTE_SIZE);
    end
  end

  // result word from stage 5
  logic    push;
  result_t res5;

  assign push       = adv && v5 && (it5.op == OP_EMIT);
  assign res5.color = pix_ok5 ? convert_color(pal_rd_data, out_format) : '0;
  assign res5.dx    = it5.dx;
  assign res5.dy    = it5.dy;
  assign res5.eol   = it5.eol;
  assign res5.eof   = it5.eof;

  // output register with skid stage
  logic head_free;

  assign head_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (skid_valid) begin
        head <= skid;
      end else if (push) begin
        head <= res5;
      end
    end else if (push) begin
      skid <= res5;
    end
  end

  assign pixel_color  = head.color;
  assign dest_x       = head.dx;
  assign dest_y       = head.dy;
  assign end_of_line  = head.eol;
  assign end_of_frame = head.eof;

  // checks
  `PSS_ASSERT(a_skid_behind_head, !skid_valid || out_valid, "skid word without output word")
  `PSS_ASSERT(a_frame_addr_range, !(v3 && it3.op == OP_EMIT) || (32'(faddr3) < 32'(FRAME_DEPTH)), "frame read address out of range")
  `PSS_ASSERT_NEXT(a_frame_wrap, emit0 && eof0, scan_column == '0 && scan_row == '0, "counters did not wrap at end of frame")

endmodule

// ===== tb/scanout_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the palette scaler scan-out: mirrors palette, frame, raster and registers
// from the words seen on the channels and checks each output word in order
// depends on pss_pkg
module scanout_checker #(
  parameter int SRC_WIDTH    = 320,
  parameter int SRC_HEIGHT   = 200,
  parameter int PALETTE_SIZE = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [7:0]                     palette_index,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic [15:0]                    source_address,
  input  logic [7:0]                     source_pixel,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [pss_pkg::RGB_W-1:0]      pixel_color,
  input  logic [pss_pkg::COL_W-1:0]      dest_x,
  input  logic [pss_pkg::COL_W-1:0]      dest_y,
  input  logic                           end_of_line,
  input  logic                           end_of_frame,
  input  logic                           cfg_write_en,
  input  logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pss_pkg::CFG_W-1:0]      cfg_data,
  output logic [31:0]                    fail_count,
  output logic [31:0]                    pending
);
  import pss_pkg::*;

  localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;

  typedef struct {
    logic [RGB_W-1:0] color;
    logic [COL_W-1:0] x;
    logic [COL_W-1:0] y;
    logic             eol;
    logic             eof;
  } pixel_word_t;

  pixel_word_t      pixel_queue[$];
  logic [RGB_W-1:0] palette_mirror [0:PALETTE_SIZE-1];
  logic [7:0]       frame_mirror [0:FRAME_DEPTH-1];
  logic [COL_W-1:0] raster_col;
  logic [COL_W-1:0] raster_row;
  logic             fmt_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic [XSTEP_W-1:0] xstep_q;
  logic [YSTEP_W-1:0] ystep_q;

  // 9.16 scaling of a raster position, held at the last source column or row
  function automatic logic [COL_W-1:0] scale_axis(input logic [COL_W-1:0] pos,
                                                   input logic [XSTEP_W-1:0] step,
                                                   input int unsigned size);
    logic [COL_W+XSTEP_W-1:0] prod;
    prod = pos * step;
    prod = prod >> FRAC_BITS;
    if (prod > size - 1) begin
      scale_axis = COL_W'(size - 1);
    end else begin
      scale_axis = prod[COL_W-1:0];
    end
  endfunction

  // destination size as the block uses it
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  // raw rgb as sent out: packed 5-6-5 or unchanged 24-bit
  function automatic logic [RGB_W-1:0] out_colour(input logic [RGB_W-1:0] rgb,
                                                  input logic fmt);
    if (fmt) return {8'h00, rgb[23:19], rgb[15:10], rgb[7:3]};
    return rgb;
  endfunction

  // sampled on the falling edge, where every channel signal is settled
  always @(negedge clk) begin : observe
    pixel_word_t      want;
    int unsigned      w;
    int unsigned      h;
    int unsigned      addr;
    logic [COL_W-1:0] sx;
    logic [COL_W-1:0] sy;
    logic [7:0]       idx;
    if (rst) begin
      pixel_queue.delete();
      raster_col = '0;
      raster_row = '0;
      fmt_q      = 1'b0;
      width_q    = 12'd640;
      height_q   = 12'd400;
      xstep_q    = 25'd32768;
      ystep_q    = 24'd32768;
      fail_count = 0;
      pending    = 0;
    end else begin
      // output word against the oldest prediction
      if (out_valid && out_ready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected output word: dest_x %0d dest_y %0d pixel_color %06h",
                 dest_x, dest_y, pixel_color);
          fail_count = fail_count + 1;
        end else begin
          want = pixel_queue.pop_front();
          if (pixel_color !== want.color) begin
            $error("pixel_color: expected %06h, actual %06h", want.color, pixel_color);
            fail_count = fail_count + 1;
          end
          if (dest_x !== want.x) begin
            $error("dest_x: expected %0d, actual %0d", want.x, dest_x);
            fail_count = fail_count + 1;
          end
          if (dest_y !== want.y) begin
            $error("dest_y: expected %0d, actual %0d", want.y, dest_y);
            fail_count = fail_count + 1;
          end
          if (end_of_line !== want.eol) begin
            $error("end_of_line: expected %0b, actual %0b", want.eol, end_of_line);
            fail_count = fail_count + 1;
          end
          if (end_of_frame !== want.eof) begin
            $error("end_of_frame: expected %0b, actual %0b", want.eof, end_of_frame);
            fail_count = fail_count + 1;
          end
        end
      end

      // register writes
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_OUT_FORMAT:  fmt_q    = cfg_data[0];
          CFG_DEST_WIDTH:  width_q  = cfg_data[DIM_W-1:0];
          CFG_DEST_HEIGHT: height_q = cfg_data[DIM_W-1:0];
          CFG_X_STEP:      xstep_q  = cfg_data[XSTEP_W-1:0];
          CFG_Y_STEP:      ystep_q  = cfg_data[YSTEP_W-1:0];
          default: ;
        endcase
      end

      // accepted input word
      if (in_valid && in_ready) begin
        case (operation)
          OP_WR_PALETTE: begin
            if (palette_index < PALETTE_SIZE) palette_mirror[palette_index] = {red, green, blue};
          end
          OP_WR_PIXEL: begin
            if (source_address < FRAME_DEPTH) frame_mirror[source_address] = source_pixel;
          end
          OP_EMIT: begin
            w    = clamp_dim(width_q);
            h    = clamp_dim(height_q);
            sx   = scale_axis(raster_col, xstep_q, SRC_WIDTH);
            sy   = scale_axis(raster_row, {1'b0, ystep_q}, SRC_HEIGHT);
            addr = sy * SRC_WIDTH + sx;
            idx  = (addr < FRAME_DEPTH) ? frame_mirror[addr] : 8'h00;
            want.color = (idx < PALETTE_SIZE) ? out_colour(palette_mirror[idx], fmt_q) : '0;
            want.x     = raster_col;
            want.y     = raster_row;
            want.eol   = (raster_col >= w - 1);
            want.eof   = want.eol && (raster_row >= h - 1);
            pixel_queue.push_back(want);
            // raster advance, wrapping at the end of the frame
            if (want.eol) begin
              raster_col = '0;
              raster_row = want.eof ? '0 : raster_row + 1'b1;
            end else begin
              raster_col = raster_col + 1'b1;
            end
          end
          default: ;
        endcase
      end
      pending = pixel_queue.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the palette scaler scan-out: clock, reset, word stimulus and verdict
// depends on pss_pkg, palette_scaler_scanout and scanout_checker
module tb;
  import pss_pkg::*;

  localparam int SRC_WIDTH    = 320;
  localparam int SRC_HEIGHT   = 200;
  localparam int PALETTE_SIZE = 256;
  localparam int MAX_DEST_DIM = 2048;
  localparam int FRAME_DEPTH  = SRC_WIDTH * SRC_HEIGHT;
  localparam logic [XSTEP_W-1:0] X_STEP_MAX = XSTEP_W'(20971520);
  localparam logic [YSTEP_W-1:0] Y_STEP_MAX = YSTEP_W'(13107200);
  localparam int DRAIN_CYCLES = 12;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           operation;
  logic [7:0]           palette_index;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic [15:0]          source_address;
  logic [7:0]           source_pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic [RGB_W-1:0]     pixel_color;
  logic [COL_W-1:0]     dest_x;
  logic [COL_W-1:0]     dest_y;
  logic                 end_of_line;
  logic                 end_of_frame;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic [31:0]          fail_count;
  logic [31:0]          pending;

  bit gaps_on;
  bit stalls_on;

  // what has been written so far, so that no pixel request reads an unwritten entry
  bit          pix_known [0:FRAME_DEPTH-1];
  logic [7:0]  pix_val   [0:FRAME_DEPTH-1];
  bit          pal_known [0:PALETTE_SIZE-1];
  int unsigned scan_x;
  int unsigned scan_y;
  logic [DIM_W-1:0]   width_set;
  logic [DIM_W-1:0]   height_set;
  logic [XSTEP_W-1:0] xstep_set;
  logic [YSTEP_W-1:0] ystep_set;

  palette_scaler_scanout #(
    .SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT),
    .PALETTE_SIZE(PALETTE_SIZE), .MAX_DEST_DIM(MAX_DEST_DIM)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .palette_index(palette_index), .red(red), .green(green), .blue(blue),
    .source_address(source_address), .source_pixel(source_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_color(pixel_color),
    .dest_x(dest_x), .dest_y(dest_y), .end_of_line(end_of_line),
    .end_of_frame(end_of_frame),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scanout_checker #(
    .SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT), .PALETTE_SIZE(PALETTE_SIZE)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .palette_index(palette_index), .red(red), .green(green), .blue(blue),
    .source_address(source_address), .source_pixel(source_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_color(pixel_color),
    .dest_x(dest_x), .dest_y(dest_y), .end_of_line(end_of_line),
    .end_of_frame(end_of_frame),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop
  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // output side back-pressure in short bursts
  initial begin : sink_pacing
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic int unsigned dim_limit(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  // present one word and hold it until accepted
  task automatic send_word(input logic [1:0] op, input logic [7:0] pidx, r, g, b,
                           input logic [15:0] saddr, input logic [7:0] spix);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    palette_index  <= pidx;
    red            <= r;
    green          <= g;
    blue           <= b;
    source_address <= saddr;
    source_pixel   <= spix;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic write_palette(input logic [7:0] idx, r, g, b);
    send_word(OP_WR_PALETTE, idx, r, g, b, 16'($urandom), 8'($urandom));
    pal_known[idx] = 1'b1;
  endtask

  task automatic write_pixel(input logic [15:0] addr, input logic [7:0] v);
    send_word(OP_WR_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), addr, v);
    if (addr < FRAME_DEPTH) begin
      pix_known[addr] = 1'b1;
      pix_val[addr]   = v;
    end
  endtask

  // pixel request, preceded by whatever writes make its source defined
  task automatic request_pixel();
    int unsigned w;
    int unsigned h;
    int unsigned sx;
    int unsigned sy;
    int unsigned addr;
    logic [63:0] prod;
    w    = dim_limit(width_set);
    h    = dim_limit(height_set);
    prod = (scan_x * xstep_set) >> FRAC_BITS;
    sx   = (prod > SRC_WIDTH - 1) ? SRC_WIDTH - 1 : 32'(prod);
    prod = (scan_y * ystep_set) >> FRAC_BITS;
    sy   = (prod > SRC_HEIGHT - 1) ? SRC_HEIGHT - 1 : 32'(prod);
    addr = sy * SRC_WIDTH + sx;
    if (!pix_known[addr]) write_pixel(16'(addr), 8'($urandom));
    if (!pal_known[pix_val[addr]]) begin
      write_palette(pix_val[addr], 8'($urandom), 8'($urandom), 8'($urandom));
    end
    send_word(OP_EMIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 8'($urandom));
    if (scan_x >= w - 1) begin
      scan_x = 0;
      scan_y = (scan_y >= h - 1) ? 0 : scan_y + 1;
    end else begin
      scan_x = scan_x + 1;
    end
  endtask

  // stop sending and let every pending word come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all five registers, written only once the block is idle
  task automatic apply_setting(input logic fmt, input logic [DIM_W-1:0] w, h,
                               input logic [XSTEP_W-1:0] xs, input logic [YSTEP_W-1:0] ys);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_OUT_FORMAT;
    cfg_data     <= CFG_W'(fmt);
    @(posedge clk);
    cfg_index    <= CFG_DEST_WIDTH;
    cfg_data     <= CFG_W'(w);
    @(posedge clk);
    cfg_index    <= CFG_DEST_HEIGHT;
    cfg_data     <= CFG_W'(h);
    @(posedge clk);
    cfg_index    <= CFG_X_STEP;
    cfg_data     <= xs;
    @(posedge clk);
    cfg_index    <= CFG_Y_STEP;
    cfg_data     <= CFG_W'(ys);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    width_set  = w;
    height_set = h;
    xstep_set  = xs;
    ystep_set  = ys;
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      request_pixel();
    end else if (pick < 72) begin
      write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 88) begin
      write_pixel(16'($urandom_range(0, FRAME_DEPTH - 1)), 8'($urandom));
    end else if (pick < 94) begin
      // past the end of the frame: dropped
      write_pixel(16'($urandom_range(FRAME_DEPTH, 65535)), 8'($urandom));
    end else if (pick < 99) begin
      send_word(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom), 8'($urandom));
    end else if (gaps_on || stalls_on) begin
      drain_results();
    end else begin
      // no pauses in a quiet phase
      request_pixel();
    end
  endtask

  task automatic run_phase(input logic fmt, input logic [DIM_W-1:0] w, h,
                           input logic [XSTEP_W-1:0] xs, input logic [YSTEP_W-1:0] ys,
                           input int unsigned count, input bit quiet);
    apply_setting(fmt, w, h, xs, ys);
    gaps_on   = !quiet && ($urandom_range(0, 3) != 0);
    stalls_on = !quiet && ($urandom_range(0, 3) != 0);
    repeat (count) random_item();
  endtask

  initial begin : stimulus
    int unsigned        w;
    int unsigned        h;
    logic [XSTEP_W-1:0] xs;
    logic [YSTEP_W-1:0] ys;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    operation      <= OP_WR_PALETTE;
    palette_index  <= '0;
    red            <= '0;
    green          <= '0;
    blue           <= '0;
    source_address <= '0;
    source_pixel   <= '0;
    cfg_write_en   <= 1'b0;
    cfg_index      <= CFG_OUT_FORMAT;
    cfg_data       <= '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    width_set  = 12'd640;
    height_set = 12'd400;
    xstep_set  = 25'd32768;
    ystep_set  = 24'd32768;
    scan_x     = 0;
    scan_y     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under the reset configuration
    write_palette(8'h00, 8'h00, 8'h00, 8'h00);
    write_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    write_palette(8'h5A, 8'h81, 8'h7E, 8'hC3);
    write_pixel(16'd0, 8'hFF);
    write_pixel(16'(FRAME_DEPTH - 1), 8'h5A);
    // addresses past the frame must not alias onto it
    write_pixel(16'(FRAME_DEPTH), 8'h00);
    write_pixel(16'hFFFF, 8'h00);
    send_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    repeat (4) request_pixel();

    // single-pixel frame in rgb565 with the steepest steps
    run_phase(1'b1, 12'd1, 12'd1, X_STEP_MAX, Y_STEP_MAX, 12, 1'b0);
    // zero width and oversized height clamp; rows run down to the last source row
    run_phase(1'b0, 12'd0, 12'd4095, 25'd0, Y_STEP_MAX, 60, 1'b0);
    // widest line reaches the last source column
    run_phase(1'b1, 12'd2048, 12'd2048, X_STEP_MAX, Y_STEP_MAX, 80, 1'b0);
    // all-ones fields: width clamps to the cap, zero height clamps to one
    run_phase(1'b0, 12'd4095, 12'd0, 25'h1FFFFFF, 24'hFFFFFF, 60, 1'b0);
    // shrunk frame with the counters already past its end
    run_phase(1'b1, 12'd6, 12'd3, 25'd98304, 24'd131072, 60, 1'b0);
    // zero steps: every pixel comes from the first source entry
    run_phase(1'b0, 12'd5, 12'd4, 25'd0, 24'd0, 40, 1'b0);

    // random small frames and steps, the last one with no idling at all
    for (int p = 0; p < 9; p++) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0:       xs = XSTEP_W'((SRC_WIDTH << FRAC_BITS) / w);
        1:       xs = XSTEP_W'($urandom_range(0, X_STEP_MAX));
        2:       xs = XSTEP_W'(1 << FRAC_BITS);
        default: xs = XSTEP_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       ys = YSTEP_W'((SRC_HEIGHT << FRAC_BITS) / h);
        1:       ys = YSTEP_W'($urandom_range(0, Y_STEP_MAX));
        2:       ys = YSTEP_W'(1 << FRAC_BITS);
        default: ys = YSTEP_W'($urandom);
      endcase
      run_phase(1'($urandom_range(0, 1)), DIM_W'(w), DIM_W'(h), xs, ys, 60, p == 8);
    end

    drain_results();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
